@@ rtl/core/ils_pkg.sv @@
// package for indexed_list_store: payload types, op and status codes
package ils_pkg;
	localparam int unsigned CapacityDefault = 64;
	localparam int unsigned PosW = 7;
	localparam int unsigned DataW = 32;

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_INSERT = 2'd1,
		OP_APPEND = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] op;
		logic [PosW-1:0] position;
		logic signed [DataW-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DataW-1:0] read_value;
		logic [1:0] status;
		logic [PosW-1:0] length;
	} rsp_t;
endpackage

@@ rtl/core/ils_shifter.sv @@
// entry memory with a shift sequencer for insert and delete that moves one entry per read/write pair
module ils_shifter #(
	parameter int unsigned Capacity = ils_pkg::CapacityDefault,
	parameter int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic dir_up,
	input logic [AddrW-1:0] lo,
	input logic [AddrW-1:0] hi,
	input logic [ils_pkg::DataW-1:0] new_value,
	input logic rd_en,
	input logic [AddrW-1:0] rd_addr,
	output logic [ils_pkg::DataW-1:0] rd_data,
	output logic busy
);
	import ils_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} state_t;

	logic [DataW-1:0] mem [Capacity];
	state_t state_q;
	logic dir_q;
	logic [AddrW-1:0] cur_q, lo_q, hi_q;
	logic [DataW-1:0] val_q;
	logic [AddrW-1:0] raddr;
	logic ren, wen;
	logic [AddrW-1:0] waddr;
	logic [DataW-1:0] wdata;

	// up: walk from hi down to lo+1 copying [i-1] into [i], then write lo
	// down: walk from lo up to hi-1 copying [i+1] into [i]
	always_comb begin
		ren = 1'b0;
		raddr = rd_addr;
		wen = 1'b0;
		waddr = cur_q;
		wdata = rd_data;
		unique case (state_q)
			S_IDLE: begin
				ren = rd_en;
			end
			S_READ: begin
				ren = 1'b1;
				raddr = dir_q ? cur_q - AddrW'(1) : cur_q + AddrW'(1);
			end
			S_WRITE: begin
				wen = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rd_data <= mem[raddr];
		end
		if (state_q == S_IDLE && start && dir_up && lo == hi) begin
			mem[lo] <= new_value;
		end
		if (state_q == S_WRITE && dir_q && cur_q - AddrW'(1) == lo_q) begin
			mem[lo_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dir_q <= 1'b0;
			cur_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			val_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && lo != hi) begin
						dir_q <= dir_up;
						cur_q <= dir_up ? hi : lo;
						lo_q <= lo;
						hi_q <= hi;
						val_q <= new_value;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (dir_q) begin
						cur_q <= cur_q - AddrW'(1);
						state_q <= (cur_q - AddrW'(1) == lo_q) ? S_IDLE : S_READ;
					end else begin
						cur_q <= cur_q + AddrW'(1);
						state_q <= (cur_q + AddrW'(1) == hi_q) ? S_IDLE : S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

@@ rtl/core/indexed_list_store.sv @@
// indexed_list_store: ordered list of signed values in one synchronous memory
// read, append, tail insert, last-entry delete and rejected requests need no shift: S_WAIT, S_SHIFT, S_OUT
// insert at p < n with n entries shifts n-p entries; delete at p < n-1 shifts n-p-1 entries
// shifts are done by the sequencer, which moves one entry per read/write pair
// one transaction at a time: next input accepted the cycle after the result is taken
// reset clears the entry count and control; entry contents stay undefined
module indexed_list_store #(
	parameter int unsigned Capacity = ils_pkg::CapacityDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input ils_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ils_pkg::rsp_t out_data
);
	import ils_pkg::*;

	localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
	localparam int unsigned CntW = $clog2(Capacity + 1);
	// compare width covers both the position field and the count
	localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

	typedef enum logic [1:0] {S_IDLE, S_WAIT, S_SHIFT, S_OUT} state_t;

	state_t state_q;
	logic [CntW-1:0] count_q;
	logic is_read_q;
	rsp_t rsp_q;

	// request decode
	logic [CmpW-1:0] pos_ext, count_ext;
	logic in_range, ins_ok, full;
	logic start, dir_up, rd_en;
	logic [AddrW-1:0] lo, hi, rd_addr;
	logic [DataW-1:0] rd_data;
	logic busy;
	logic accept;
	logic [CntW-1:0] next_count;
	status_t st;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign pos_ext = CmpW'(in_data.position);
	assign count_ext = CmpW'(count_q);
	assign full = (count_q >= CntW'(Capacity));
	assign in_range = pos_ext < count_ext;
	assign ins_ok = pos_ext <= count_ext;

	always_comb begin
		st = ST_DONE;
		start = 1'b0;
		dir_up = 1'b1;
		rd_en = 1'b0;
		lo = AddrW'(in_data.position);
		hi = count_q[AddrW-1:0];
		rd_addr = AddrW'(in_data.position);
		next_count = count_q;
		unique case (op_t'(in_data.op))
			OP_READ: begin
				if (in_range) rd_en = 1'b1;
				else st = ST_RANGE;
			end
			OP_INSERT: begin
				if (!ins_ok) st = ST_RANGE;
				else if (full) st = ST_FULL;
				else begin
					start = 1'b1;
					next_count = count_q + CntW'(1);
				end
			end
			OP_APPEND: begin
				lo = count_q[AddrW-1:0];
				if (full) st = ST_FULL;
				else begin
					start = 1'b1;
					next_count = count_q + CntW'(1);
				end
			end
			OP_DELETE: begin
				dir_up = 1'b0;
				hi = AddrW'(count_q - CntW'(1));
				if (!in_range) st = ST_RANGE;
				else begin
					start = 1'b1;
					next_count = count_q - CntW'(1);
				end
			end
			default: ;
		endcase
	end

	ils_shifter #(.Capacity(Capacity), .AddrW(AddrW)) u_shift (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && start),
		.dir_up(dir_up),
		.lo(lo),
		.hi(hi),
		.new_value(in_data.value),
		.rd_en(accept && rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.busy(busy)
	);

	// the result register doubles as the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			is_read_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= next_count;
						is_read_q <= rd_en;
						rsp_q.read_value <= '1;
						rsp_q.status <= st;
						rsp_q.length <= PosW'(next_count);
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					// memory read data arrives this cycle
					if (is_read_q) rsp_q.read_value <= rd_data;
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (!busy) state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign out_data = rsp_q;
endmodule

@@ test/indexed_list_store_chk.sv @@
// checker for indexed_list_store: watches both channels, predicts and compares responses
module indexed_list_store_chk #(
	parameter int unsigned Capacity = ils_pkg::CapacityDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input ils_pkg::req_t in_data,
	input logic out_valid,
	input logic out_ready,
	input ils_pkg::rsp_t out_data,
	output int unsigned fail_count,
	output int unsigned pending
);
	import ils_pkg::*;

	logic signed [DataW-1:0] model_list[$];
	rsp_t expected_rsp[$];

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int unsigned n;
		n = model_list.size();
		o.read_value = -1;
		o.status = ST_DONE;
		case (op_t'(r.op))
			OP_READ: begin
				if (r.position < n) o.read_value = model_list[r.position];
				else o.status = ST_RANGE;
			end
			OP_INSERT: begin
				if (r.position > n) o.status = ST_RANGE;
				else if (n >= Capacity) o.status = ST_FULL;
				else model_list.insert(r.position, r.value);
			end
			OP_APPEND: begin
				if (n >= Capacity) o.status = ST_FULL;
				else model_list.push_back(r.value);
			end
			default: begin
				if (r.position < n) model_list.delete(r.position);
				else o.status = ST_RANGE;
			end
		endcase
		o.length = PosW'(model_list.size());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			model_list.delete();
			expected_rsp.delete();
		end else begin
			if (in_valid && in_ready) expected_rsp.push_back(list_apply(in_data));
			if (out_valid && out_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_rsp.pop_front();
					if (e !== out_data) begin
						$display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
							$time, e.read_value, e.status, e.length,
							out_data.read_value, out_data.status, out_data.length);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_rsp.size();
		end
	end
endmodule

@@ test/indexed_list_store_tb.sv @@
// testbench top for indexed_list_store: stimulus, receiver pacing and verdict
module indexed_list_store_tb;
	import ils_pkg::*;

	localparam int unsigned Cap = 64;
	localparam int unsigned Limit = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	rsp_t out_data;
	int unsigned fail_count, pending;
	int unsigned live_len = 0;	// length tracked from accepted transactions' responses
	bit quiet = 0;	// no idling in the last part
	bit hold_off = 0;
	int unsigned idle_cycles = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	indexed_list_store #(.Capacity(Cap)) DUT (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
	);

	indexed_list_store_chk #(.Capacity(Cap)) checker_i (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
		.fail_count, .pending
	);

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= Limit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int unsigned k;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
				for (k = 0; k < 300; k++) @(negedge clk);
				hold_off = 0;
				out_ready <= 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_ready <= 1;
			end else begin
				out_ready <= 1;
			end
		end
	end

	// follow the list length from responses so random positions land near the range
	always @(posedge clk) if (out_valid && out_ready) live_len <= out_data.length;

	task automatic send(input op_t op, input int unsigned pos, input logic [31:0] val);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= '{op: op, position: PosW'(pos), value: val};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned i, p, r;
		op_t op;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: empty list corners
		send(OP_READ, 0, 0);
		send(OP_DELETE, 0, 0);
		send(OP_INSERT, 1, 5);
		send(OP_DELETE, 127, 0);
		send(OP_INSERT, 0, 32'h8000_0000);
		send(OP_APPEND, 127, 32'h7fff_ffff);
		send(OP_INSERT, 2, 32'hffff_ffff);
		send(OP_INSERT, 1, 0);
		send(OP_READ, 0, 0);
		send(OP_READ, 3, 0);
		send(OP_READ, 4, 0);
		send(OP_READ, 127, 0);
		send(OP_DELETE, 1, 0);
		send(OP_DELETE, 2, 0);
		send(OP_DELETE, 3, 0);
		// fill to capacity, then full cases
		for (i = 0; i < Cap; i++) send(OP_APPEND, 0, $urandom);
		send(OP_APPEND, 0, 1);
		send(OP_INSERT, 0, 1);
		send(OP_INSERT, Cap, 1);
		send(OP_INSERT, Cap + 1, 1);
		send(OP_READ, Cap - 1, 0);
		send(OP_DELETE, Cap - 1, 0);
		send(OP_DELETE, 0, 0);
		// long receiver hold-off while the sender keeps offering
		hold_off = 1;
		for (i = 0; i < 20; i++) send(OP_READ, $urandom_range(0, 70), 0);
		// random part, biased toward valid positions
		for (i = 0; i < 1450; i++) begin
			if (i == 1300) quiet = 1;
			r = $urandom_range(0, 9);
			op = op_t'($urandom_range(0, 3));
			if (live_len > 50 && op == OP_APPEND && $urandom_range(0, 1)) op = OP_DELETE;
			if (r == 0) p = $urandom_range(0, 127);
			else p = $urandom_range(0, live_len + 1);
			send(op, p, rand_val());
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/ils_pkg.sv
rtl/core/ils_shifter.sv
rtl/core/indexed_list_store.sv
test/indexed_list_store_chk.sv
test/indexed_list_store_tb.sv
